// ===== hdl/isdp_pkg.sv =====
// ----------------------------------------------------------------------------
// isdp_pkg
// Shared types and constants of the int8 scaled dot product block.
// ----------------------------------------------------------------------------
package isdp_pkg;

  // Default lane count, and the number of int8 lanes one 64-bit word holds
  localparam int unsigned LANES_DEF  = 8;
  localparam int unsigned WORD_BYTES = 8;

  localparam int unsigned PROD_W  = 16;  // int8 x int8 product
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned SCALE_W = 32;
  localparam int unsigned ROW_W   = 20;
  localparam int unsigned END_W   = 21;
  localparam int unsigned CFG_W   = 32;

  localparam logic [ACC_W-1:0]   ACT_SCALE_RST = 32'h0100_0000;  // 1.0 in Q8.24
  localparam logic [END_W-1:0]   END_ROW_RST   = 21'h10_0000;

  typedef enum logic [1:0] {
    REG_ACT_SCALE = 2'd0,
    REG_FIRST_ROW = 2'd1,
    REG_END_ROW   = 2'd2
  } cfg_reg_e;

  // Control that travels with the lane products into the merge stage
  typedef struct packed {
    logic               row_end;
    logic [SCALE_W-1:0] row_scale;
    logic [ROW_W-1:0]   row_index;
  } item_t;

  // Finished row handed to the scaling pipeline
  typedef struct packed {
    logic [ACC_W-1:0]   acc;
    logic [SCALE_W-1:0] row_scale;
    logic [ROW_W-1:0]   row_index;
  } job_t;

endpackage

// ===== hdl/isdp_lane.sv =====
// ----------------------------------------------------------------------------
// isdp_lane
// One multiply lane: signed int8 weight times signed int8 activation,
// registered.
// ----------------------------------------------------------------------------
module isdp_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [7:0]                          w_i,
  input  logic [7:0]                          a_i,
  output logic signed [isdp_pkg::PROD_W-1:0]  prod_o
);

  logic signed [isdp_pkg::PROD_W-1:0] prod_d;
  logic signed [isdp_pkg::PROD_W-1:0] prod_q;

  assign prod_d = $signed(w_i) * $signed(a_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/isdp_merge.sv =====
// ----------------------------------------------------------------------------
// isdp_merge
// Sums the lane products into the wrapping row accumulator and hands each
// finished row to the scaling pipeline.
// ----------------------------------------------------------------------------
module isdp_merge #(
  parameter int unsigned NL = isdp_pkg::LANES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  logic                             a_valid_i,
  output logic                             a_ready_o,
  input  isdp_pkg::item_t                  item_i,
  input  logic [NL*isdp_pkg::PROD_W-1:0]   prod_i,
  output logic                             job_valid_o,
  output isdp_pkg::job_t                   job_o,
  input  logic                             job_ready_i
);

  localparam int unsigned SUM_W = isdp_pkg::PROD_W + $clog2(NL);

  logic signed [SUM_W-1:0]          lane_sum;
  logic [isdp_pkg::ACC_W-1:0]       acc_sum;
  logic [isdp_pkg::ACC_W-1:0]       acc_d, acc_q;
  logic                             job_valid_d, job_valid_q;
  isdp_pkg::job_t                   job_d, job_q;
  logic                             take;

  always_comb begin
    lane_sum = '0;
    for (int unsigned i = 0; i < NL; i++) begin
      lane_sum = lane_sum + SUM_W'($signed(prod_i[i*isdp_pkg::PROD_W +: isdp_pkg::PROD_W]));
    end
  end

  assign acc_sum   = acc_q + isdp_pkg::ACC_W'(lane_sum);
  assign a_ready_o = !job_valid_q || job_ready_i;
  assign take      = a_valid_i && a_ready_o;

  always_comb begin
    acc_d       = acc_q;
    job_valid_d = job_valid_q && !job_ready_i;
    job_d       = job_q;
    if (take) begin
      acc_d = item_i.row_end ? '0 : acc_sum;
      if (item_i.row_end) begin
        job_valid_d     = 1'b1;
        job_d.acc       = acc_sum;
        job_d.row_scale = item_i.row_scale;
        job_d.row_index = item_i.row_index;
      end
    end
    if (clear_i) begin
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      job_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

// ===== hdl/isdp_scale.sv =====
// ----------------------------------------------------------------------------
// isdp_scale
// Four-stage scaling pipeline: accumulator times row scale, times
// activation scale in two halves, clamp and saturate to signed Q16.16.
// ----------------------------------------------------------------------------
module isdp_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [isdp_pkg::SCALE_W-1:0]      act_scale_i,
  input  logic                              job_valid_i,
  output logic                              job_ready_o,
  input  isdp_pkg::job_t                    job_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [isdp_pkg::ACC_W-1:0] logit_o,
  output logic [isdp_pkg::ROW_W-1:0]        row_index_o
);

  localparam logic signed [49:0] BIG     = 50'sd1 << 48;
  localparam logic signed [50:0] SAT_MAX = 51'sd2147483647;
  localparam logic signed [50:0] SAT_MIN = -51'sd2147483648;

  // stage valids: c = row product, d = act products, e = clamp, f = output
  logic vc_q, vd_q, ve_q, vf_q;
  logic rc, rd, re, rf;

  logic signed [64:0]              m1_full;
  logic signed [63:0]              m1_q;
  logic signed [47:0]              p1;
  logic signed [64:0]              mh_full, ml_full;
  logic signed [63:0]              mh_q, ml_q;
  logic signed [49:0]              t1_d, t1_q;
  logic signed [47:0]              t2_q;
  logic signed [50:0]              sum;
  logic signed [isdp_pkg::ACC_W-1:0] logit_d, logit_q;
  logic [isdp_pkg::ROW_W-1:0]      idx_c_q, idx_d_q, idx_e_q, idx_f_q;

  assign rf = !vf_q || out_ready_i;
  assign re = !ve_q || rf;
  assign rd = !vd_q || re;
  assign rc = !vc_q || rd;
  assign job_ready_o = rc;

  assign m1_full = $signed(job_i.acc) * $signed({1'b0, job_i.row_scale});
  assign p1      = m1_q[63:16];
  assign mh_full = p1 * $signed({1'b0, act_scale_i[31:16]});
  assign ml_full = p1 * $signed({1'b0, act_scale_i[15:0]});

  always_comb begin
    t1_d = 50'(mh_q);
    if (mh_q > 64'(BIG)) begin
      t1_d = BIG;
    end else if (mh_q < -64'(BIG)) begin
      t1_d = -BIG;
    end
  end

  assign sum = 51'(t1_q) + 51'(t2_q);

  always_comb begin
    logit_d = sum[31:0];
    if (sum > SAT_MAX) begin
      logit_d = SAT_MAX[31:0];
    end else if (sum < SAT_MIN) begin
      logit_d = SAT_MIN[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else begin
      if (rc) vc_q <= job_valid_i;
      if (rd) vd_q <= vc_q;
      if (re) ve_q <= vd_q;
      if (rf) vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rc) begin
      m1_q    <= m1_full[63:0];
      idx_c_q <= job_i.row_index;
    end
    if (rd) begin
      mh_q    <= mh_full[63:0];
      ml_q    <= ml_full[63:0];
      idx_d_q <= idx_c_q;
    end
    if (re) begin
      t1_q    <= t1_d;
      t2_q    <= ml_q[63:16];
      idx_e_q <= idx_d_q;
    end
    if (rf) begin
      logit_q <= logit_d;
      idx_f_q <= idx_e_q;
    end
  end

  assign out_valid_o = vf_q;
  assign logit_o     = logit_q;
  assign row_index_o = idx_f_q;

endmodule

// ===== hdl/int8_scaled_dot_product_top.sv =====
// ----------------------------------------------------------------------------
// int8_scaled_dot_product_top
// Per-row scaled int8 dot product with range control.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while in_ready_o is high: up to eight
// signed int8 weight/activation lane pairs multiplied side by side, summed
// into a wrapping 32-bit row accumulator. A transaction with row_end set
// produces one logit (accumulator * row_scale * act_scale, signed Q16.16,
// saturated) with its row index. The lane stage loads at the accepting
// edge, then the merge stage and a four-stage scaling pipeline follow,
// each registered. Other transactions produce nothing. Transactions
// arriving while the current row is at or past end_row are dropped.
// Writing first_row restarts the range and clears the accumulator; write
// configuration only while the block is idle.
// ----------------------------------------------------------------------------
module int8_scaled_dot_product_top #(
  parameter int unsigned LANES = isdp_pkg::LANES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [isdp_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [63:0]                       weight_bytes_i,
  input  logic [63:0]                       act_bytes_i,
  input  logic [isdp_pkg::SCALE_W-1:0]      row_scale_i,
  input  logic                              row_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [isdp_pkg::ACC_W-1:0] logit_o,
  output logic [isdp_pkg::ROW_W-1:0]        row_index_o
);

  localparam int unsigned NL =
    (LANES < isdp_pkg::WORD_BYTES) ? LANES : isdp_pkg::WORD_BYTES;

  logic [isdp_pkg::SCALE_W-1:0] act_scale_q;
  logic [isdp_pkg::END_W-1:0]   end_row_q;
  logic [isdp_pkg::END_W-1:0]   cur_row_d, cur_row_q;
  logic                         first_row_wr;
  logic                         past;
  logic                         accept, a_load;
  logic                         a_valid_q;
  isdp_pkg::item_t              a_item_q;
  logic                         merge_ready;
  logic [NL*isdp_pkg::PROD_W-1:0] prod;
  logic                         job_valid, job_ready;
  isdp_pkg::job_t               job;

  assign first_row_wr = cfg_we_i && (cfg_idx_i == isdp_pkg::REG_FIRST_ROW);
  assign past         = cur_row_q >= end_row_q;
  assign in_ready_o   = !a_valid_q || merge_ready;
  assign accept       = in_valid_i && in_ready_o;
  assign a_load       = accept && !past;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_scale_q <= isdp_pkg::ACT_SCALE_RST;
      end_row_q   <= isdp_pkg::END_ROW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        isdp_pkg::REG_ACT_SCALE: act_scale_q <= cfg_wdata_i;
        isdp_pkg::REG_END_ROW:   end_row_q   <= cfg_wdata_i[isdp_pkg::END_W-1:0];
        default: ;
      endcase
    end
  end

  // row counter: advance on each kept row end, reload on a first_row write
  always_comb begin
    cur_row_d = cur_row_q;
    if (first_row_wr) begin
      cur_row_d = {1'b0, cfg_wdata_i[isdp_pkg::ROW_W-1:0]};
    end else if (a_load && row_end_i) begin
      cur_row_d = cur_row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q <= '0;
      a_valid_q <= 1'b0;
    end else begin
      cur_row_q <= cur_row_d;
      if (in_ready_o) begin
        a_valid_q <= a_load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_item_q.row_end   <= row_end_i;
      a_item_q.row_scale <= row_scale_i;
      a_item_q.row_index <= cur_row_q[isdp_pkg::ROW_W-1:0];
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    isdp_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (a_load),
      .w_i    (weight_bytes_i[8*g +: 8]),
      .a_i    (act_bytes_i[8*g +: 8]),
      .prod_o (prod[g*isdp_pkg::PROD_W +: isdp_pkg::PROD_W])
    );
  end

  isdp_merge #(
    .NL (NL)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (first_row_wr),
    .a_valid_i   (a_valid_q),
    .a_ready_o   (merge_ready),
    .item_i      (a_item_q),
    .prod_i      (prod),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  isdp_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .act_scale_i (act_scale_q),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .logit_o     (logit_o),
    .row_index_o (row_index_o)
  );

  // dropped transactions never enter the lane stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && past |=> !a_valid_q)
    else $error("transaction past end_row entered the lane stage");

  // a kept row end advances the row counter by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_load && row_end_i && !first_row_wr |=> cur_row_q == $past(cur_row_q) + 1'b1)
    else $error("row counter did not advance on row end");

  // a first_row write reloads the row counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_row_wr |=> cur_row_q == {1'b0, $past(cfg_wdata_i[isdp_pkg::ROW_W-1:0])})
    else $error("row counter not reloaded by first_row write");

endmodule
